>>> rtl/assert_macros.svh
// Assertion helpers for the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("queue check failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("queue check failed");

`endif

>>> rtl/comq_pkg.sv
package comq_pkg;

   // Fixed field widths of the request and response words
   localparam int MODE_W    = 2;
   localparam int CLASS_W   = 4;
   localparam int IN_TAG_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int OUT_TAG_W = 16;
   localparam int FILL_W    = 4;
   localparam int NUM_CODES = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SELECT = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   // Per-cell update command
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // Per-cell compare results
   typedef struct packed {
      logic                 hit;
      logic [NUM_CODES-1:0] present;
   } cell_stat_type;

endpackage

>>> rtl/comq_cell.sv
module comq_cell #(
   parameter int TAG_WIDTH = 16
) (
   input  logic                             clock,
   input  comq_pkg::cell_ctl_type           ctl,
   input  logic                             occupied,
   input  logic [comq_pkg::CLASS_W-1:0]     key_class,
   input  logic [comq_pkg::CLASS_W-1:0]     new_class,
   input  logic [TAG_WIDTH-1:0]             new_tag,
   input  logic [comq_pkg::CLASS_W-1:0]     nb_class,
   input  logic [TAG_WIDTH-1:0]             nb_tag,
   output comq_pkg::cell_stat_type          stat,
   output logic [comq_pkg::CLASS_W-1:0]     cls_out,
   output logic [TAG_WIDTH-1:0]             tag_out
);
   import comq_pkg::*;

   logic [CLASS_W-1:0]   class_ff, class_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // Take the neighbor's entry on a shift, the new entry on a load, else hold
   always_comb begin
      class_in = class_ff;
      tag_in   = tag_ff;
      if (ctl.shift) begin
         class_in = nb_class;
         tag_in   = nb_tag;
      end else if (ctl.load) begin
         class_in = new_class;
         tag_in   = new_tag;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
      tag_ff   <= tag_in;
   end

   // Compare against the search key and flag the held class
   assign stat.hit     = occupied && (class_ff == key_class);
   assign stat.present = occupied ? (NUM_CODES'(1) << class_ff) : '0;
   assign cls_out      = class_ff;
   assign tag_out      = tag_ff;

endmodule

>>> rtl/class_ordered_message_queue_unit.sv
// An insert or no-op word goes from accept to the apply step, a remove word
// through a first-match search and apply, a select word through key search, search
// and apply. One word at a time; a new word is taken only once the last leaves apply,
// and a response left waiting holds the word in the apply step until taken.
// Reset: synchronous, active high; clears the fill count and the handshakes.
// Cell contents are not cleared; only cells below the fill count are ever read.
`include "assert_macros.svh"

module class_ordered_message_queue_unit #(
   parameter int DEPTH     = 8,
   parameter int TAG_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [comq_pkg::MODE_W-1:0]       req_mode,
   input  logic [comq_pkg::CLASS_W-1:0]      req_msg_class,
   input  logic [comq_pkg::IN_TAG_W-1:0]     req_msg_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [comq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [comq_pkg::OUT_TAG_W-1:0]    rsp_out_tag,
   output logic [comq_pkg::CLASS_W-1:0]      rsp_out_class,
   output logic [comq_pkg::FILL_W-1:0]       rsp_fill_count
);
   import comq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_FIND,
      ST_APPLY
   } state_type;

   state_type            state_ff;
   mode_type             mode_ff;
   logic [CLASS_W-1:0]   key_ff;
   logic [TAG_WIDTH-1:0] tag_ff;
   logic [PW-1:0]        pos_ff;
   logic                 found_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OUT_TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [CLASS_W-1:0]   rsp_class_ff, rsp_class_in;
   logic [FILL_W-1:0]    rsp_fill_ff;

   logic [CLASS_W-1:0]   cls_q [DEPTH];
   logic [TAG_WIDTH-1:0] tag_q [DEPTH];
   cell_stat_type        stat  [DEPTH];
   cell_ctl_type         ctl   [DEPTH];
   logic [DEPTH-1:0]     hit_vec;

   logic [NUM_CODES-1:0] present_all;
   logic [CLASS_W-1:0]   lowest_class;
   logic [PW-1:0]        first_pos;
   logic                 any_hit;
   logic                 apply_go;
   logic                 is_full;
   logic                 is_empty;
   logic                 do_load;
   logic                 do_shift;
   logic                 insert_go;
   logic                 select_check;

   // Row of entry cells, each but the top one shifting down from its upper neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [CLASS_W-1:0]   nb_class;
      logic [TAG_WIDTH-1:0] nb_tag;

      if (i == DEPTH - 1) begin : g_last
         assign nb_class = cls_q[i];
         assign nb_tag   = tag_q[i];
      end else begin : g_mid
         assign nb_class = cls_q[i+1];
         assign nb_tag   = tag_q[i+1];
      end

      assign ctl[i].load  = apply_go && do_load && (count_ff == CW'(i));
      assign ctl[i].shift = apply_go && do_shift && (pos_ff <= PW'(i));
      assign hit_vec[i]   = stat[i].hit;

      comq_cell #(
         .TAG_WIDTH (TAG_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .occupied  (count_ff > CW'(i)),
         .key_class (key_ff),
         .new_class (key_ff),
         .new_tag   (tag_ff),
         .nb_class  (nb_class),
         .nb_tag    (nb_tag),
         .stat      (stat[i]),
         .cls_out   (cls_q[i]),
         .tag_out   (tag_q[i])
      );
   end

   // Gather the classes held and pick the most urgent one
   always_comb begin
      present_all = '0;
      for (int i = 0; i < DEPTH; i++) begin
         present_all = present_all | stat[i].present;
      end
      lowest_class = '0;
      for (int c = NUM_CODES - 1; c >= 0; c--) begin
         if (present_all[c]) begin
            lowest_class = CLASS_W'(c);
         end
      end
   end

   // Find the oldest cell matching the key
   always_comb begin
      first_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            first_pos = PW'(i);
         end
      end
      any_hit = |hit_vec;
   end

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign apply_go = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   // Build the response word and the cell commands
   always_comb begin
      rsp_status_in = STAT_DONE;
      rsp_tag_in    = '0;
      rsp_class_in  = '0;
      count_in      = count_ff;
      do_load       = 1'b0;
      do_shift      = 1'b0;
      case (mode_ff)
         MODE_INSERT: begin
            if (is_full) begin
               rsp_status_in = STAT_FULL;
            end else begin
               do_load  = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_REMOVE: begin
            if (!found_ff) begin
               rsp_status_in = STAT_NOT_FOUND;
            end else begin
               do_shift     = 1'b1;
               rsp_tag_in   = OUT_TAG_W'(32'(tag_q[pos_ff]));
               rsp_class_in = cls_q[pos_ff];
               count_in     = count_ff - CW'(1);
            end
         end
         MODE_SELECT: begin
            if (is_empty) begin
               rsp_status_in = STAT_EMPTY;
            end else begin
               rsp_tag_in   = OUT_TAG_W'(32'(tag_q[pos_ff]));
               rsp_class_in = cls_q[pos_ff];
            end
         end
         default: begin
         end
      endcase
   end

   // Sequence one word through key search, search and apply, as its mode needs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise the response on apply, hold it until it is taken
         rsp_valid_ff <= apply_go || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff <= mode_type'(req_mode);
                  key_ff  <= req_msg_class;
                  tag_ff  <= TAG_WIDTH'(32'(req_msg_tag));
                  case (mode_type'(req_mode))
                     MODE_REMOVE: state_ff <= ST_FIND;
                     MODE_SELECT: state_ff <= ST_KEY;
                     default:     state_ff <= ST_APPLY;
                  endcase
               end
            end
            ST_KEY: begin
               key_ff   <= lowest_class;
               state_ff <= ST_FIND;
            end
            ST_FIND: begin
               pos_ff   <= first_pos;
               found_ff <= any_hit;
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (apply_go) begin
                  rsp_status_ff <= rsp_status_in;
                  rsp_tag_ff    <= rsp_tag_in;
                  rsp_class_ff  <= rsp_class_in;
                  rsp_fill_ff   <= FILL_W'(32'(count_in));
                  count_ff      <= count_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_tag    = rsp_tag_ff;
   assign rsp_out_class  = rsp_class_ff;
   assign rsp_fill_count = rsp_fill_ff;

   assign insert_go    = apply_go && (mode_ff == MODE_INSERT) && !is_full;
   assign select_check = (state_ff == ST_APPLY) && (mode_ff == MODE_SELECT) && !is_empty;

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `ASSERT_NEXT(a_insert_grows, clock, reset, insert_go, count_ff == $past(count_ff) + CW'(1))
   `ASSERT_NEXT(a_rsp_source, clock, reset, !rsp_valid_ff && !apply_go, !rsp_valid_ff)
   `ASSERT_SAME(a_select_hits, clock, reset, select_check, found_ff)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import comq_pkg::*;

   localparam int DEPTH      = 8;
   localparam int TAG_WIDTH  = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 300;

   typedef struct {
      mode_type              mode;
      logic [CLASS_W-1:0]    cls;
      logic [IN_TAG_W-1:0]   tag;
   } request_word_type;

   typedef struct {
      status_type            status;
      logic [OUT_TAG_W-1:0]  tag;
      logic [CLASS_W-1:0]    cls;
      logic [FILL_W-1:0]     fill;
   } response_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [CLASS_W-1:0]    req_msg_class = '0;
   logic [IN_TAG_W-1:0]   req_msg_tag = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [OUT_TAG_W-1:0]  rsp_out_tag;
   logic [CLASS_W-1:0]    rsp_out_class;
   logic [FILL_W-1:0]     rsp_fill_count;

   // Words waiting to be offered, and responses the shadow queue predicts
   request_word_type   request_backlog[$];
   response_word_type  expected_responses[$];

   // Shadow copy of the message queue
   logic [CLASS_W-1:0]    shadow_class[DEPTH];
   logic [TAG_WIDTH-1:0]  shadow_tag[DEPTH];
   int                    shadow_count = 0;

   int   send_idle_pct = 12;
   int   recv_idle_pct = 48;
   int   error_count = 0;
   int   idle_cycles = 0;
   int   hold_left = 0;
   bit   hold_request = 1'b0;
   bit   hold_done = 1'b0;

   class_ordered_message_queue_unit #(
      .DEPTH     (DEPTH),
      .TAG_WIDTH (TAG_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_msg_class  (req_msg_class),
      .req_msg_tag    (req_msg_tag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_class  (rsp_out_class),
      .rsp_fill_count (rsp_fill_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Format one response word for a report line
   function automatic string word_text(input logic [STATUS_W-1:0] st,
                                       input logic [OUT_TAG_W-1:0] tg,
                                       input logic [CLASS_W-1:0] cl,
                                       input logic [FILL_W-1:0] fl);
      return $sformatf("status=%0d tag=%h class=%0d fill=%0d", st, tg, cl, fl);
   endfunction

   // Apply one accepted word to the shadow queue and record its response
   task automatic shadow_queue_op(input logic [MODE_W-1:0] mode_bits,
                                  input logic [CLASS_W-1:0] cls,
                                  input logic [IN_TAG_W-1:0] tag);
      response_word_type rsp;
      int pos;
      rsp.status = STAT_DONE;
      rsp.tag    = '0;
      rsp.cls    = '0;
      case (mode_type'(mode_bits))
         MODE_INSERT: begin
            if (shadow_count >= DEPTH) begin
               rsp.status = STAT_FULL;
            end else begin
               shadow_class[shadow_count] = cls;
               shadow_tag[shadow_count]   = tag[TAG_WIDTH-1:0];
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            pos = -1;
            for (int i = 0; i < shadow_count; i++) begin
               if (pos < 0 && shadow_class[i] == cls) pos = i;
            end
            if (pos < 0) begin
               rsp.status = STAT_NOT_FOUND;
            end else begin
               rsp.tag = OUT_TAG_W'(shadow_tag[pos]);
               rsp.cls = shadow_class[pos];
               // close the gap behind the removed entry
               for (int i = pos; i + 1 < shadow_count; i++) begin
                  shadow_class[i] = shadow_class[i+1];
                  shadow_tag[i]   = shadow_tag[i+1];
               end
               shadow_count--;
            end
         end
         MODE_SELECT: begin
            if (shadow_count == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               pos = 0;
               for (int i = 1; i < shadow_count; i++) begin
                  if (shadow_class[i] < shadow_class[pos]) pos = i;
               end
               rsp.tag = OUT_TAG_W'(shadow_tag[pos]);
               rsp.cls = shadow_class[pos];
            end
         end
         default: ;
      endcase
      rsp.fill = FILL_W'(shadow_count);
      expected_responses.push_back(rsp);
   endtask

   task automatic queue_word(input mode_type mode, input logic [CLASS_W-1:0] cls,
                             input logic [IN_TAG_W-1:0] tag);
      request_word_type w;
      w.mode = mode;
      w.cls  = cls;
      w.tag  = tag;
      request_backlog.push_back(w);
   endtask

   // Pick fill or drain runs at random so the queue hits both full and empty
   task automatic queue_random_words(input int count);
      bit filling;
      int r;
      mode_type m;
      logic [CLASS_W-1:0] c;
      logic [IN_TAG_W-1:0] t;
      filling = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % 16 == 0) filling = 1'($urandom_range(1, 0));
         r = $urandom_range(99, 0);
         if (filling) begin
            if (r < 60)      m = MODE_INSERT;
            else if (r < 78) m = MODE_REMOVE;
            else if (r < 95) m = MODE_SELECT;
            else             m = MODE_NOP;
         end else begin
            if (r < 20)      m = MODE_INSERT;
            else if (r < 70) m = MODE_REMOVE;
            else if (r < 95) m = MODE_SELECT;
            else             m = MODE_NOP;
         end
         r = $urandom_range(99, 0);
         if (r < 60)      c = CLASS_W'($urandom_range(4, 0));
         else if (r < 90) c = CLASS_W'($urandom_range(10, 0));
         else             c = CLASS_W'($urandom_range(15, 11));
         r = $urandom_range(19, 0);
         if (r == 0)      t = '0;
         else if (r == 1) t = '1;
         else             t = IN_TAG_W'($urandom);
         queue_word(m, c, t);
      end
   endtask

   // Offer words from the backlog; predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) shadow_queue_op(req_mode, req_msg_class, req_msg_tag);
         if (!req_valid || req_ready) begin
            if (request_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_mode      <= request_backlog[0].mode;
               req_msg_class <= request_backlog[0].cls;
               req_msg_tag   <= request_backlog[0].tag;
               void'(request_backlog.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each response against the oldest prediction; drive rsp_ready
   always @(posedge clock) begin
      response_word_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response: %s",
                           word_text(rsp_status, rsp_out_tag, rsp_out_class,
                                     rsp_fill_count));
            end else begin
               exp = expected_responses.pop_front();
               if (rsp_status !== exp.status || rsp_out_tag !== exp.tag ||
                   rsp_out_class !== exp.cls || rsp_fill_count !== exp.fill) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected %s, got %s",
                              word_text(exp.status, exp.tag, exp.cls, exp.fill),
                              word_text(rsp_status, rsp_out_tag, rsp_out_class,
                                        rsp_fill_count));
               end
            end
         end
         // hold off once for a long stretch so the input side backs up
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // End the run if neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (request_backlog.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases and a no-op word
      queue_word(MODE_SELECT, 4'd0, 16'h0000);
      queue_word(MODE_REMOVE, 4'd3, 16'hffff);
      queue_word(MODE_NOP, 4'd15, 16'hffff);
      // fill to capacity, with a repeated class and classes past update
      queue_word(MODE_INSERT, 4'd10, 16'hffff);
      queue_word(MODE_INSERT, 4'd0, 16'h0000);
      queue_word(MODE_INSERT, 4'd15, 16'haaaa);
      queue_word(MODE_INSERT, 4'd5, 16'h5555);
      queue_word(MODE_INSERT, 4'd0, 16'h1111);
      queue_word(MODE_INSERT, 4'd11, 16'h2222);
      queue_word(MODE_INSERT, 4'd1, 16'h3333);
      queue_word(MODE_INSERT, 4'd7, 16'h4444);
      // insert into a full queue
      queue_word(MODE_INSERT, 4'd2, 16'h7777);
      // select and remove the oldest of a repeated class
      queue_word(MODE_SELECT, 4'd9, 16'h1234);
      queue_word(MODE_REMOVE, 4'd0, 16'h0000);
      queue_word(MODE_SELECT, 4'd0, 16'h0000);
      // remove with no match, then from the middle, the front and the back
      queue_word(MODE_REMOVE, 4'd9, 16'h0000);
      queue_word(MODE_REMOVE, 4'd15, 16'h0000);
      queue_word(MODE_REMOVE, 4'd10, 16'h0000);
      queue_word(MODE_REMOVE, 4'd7, 16'h0000);
      queue_word(MODE_NOP, 4'd5, 16'h5a5a);
      queue_word(MODE_SELECT, 4'd0, 16'h0000);
      wait_drained();

      queue_random_words(130);
      wait_drained();

      send_idle_pct = 48;
      recv_idle_pct = 12;
      queue_random_words(135);
      hold_request = 1'b1;
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_words(135);
      wait_drained();

      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/comq_pkg.sv
rtl/comq_cell.sv
rtl/class_ordered_message_queue_unit.sv
sim/testbench.sv
